// ----- rtl/dqe_pkg.sv -----
// types and codes shared by the deque cells and the top level
package dqe_pkg;

    // opcodes carried by an input transaction
    typedef enum logic [2:0] {
        OP_NOP        = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_PUSH_REAR  = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_POP_REAR   = 3'd4
    } opcode_t;

    // status codes returned with each result
    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2
    } status_t;

    // input transaction payload
    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] push_value;
    } in_item_t;

    // result transaction payload
    typedef struct packed {
        logic signed [31:0] front_value;
        logic signed [31:0] rear_value;
        logic               is_empty;
        logic               is_full;
        logic [4:0]         occupancy;
        logic [1:0]         status;
    } out_item_t;

    // shift and load controls broadcast to every cell
    typedef struct packed {
        logic push_front;
        logic push_rear;
        logic pop_front;
        logic pop_rear;
    } cell_ctrl_t;

endpackage

// ----- rtl/dqe_cell.sv -----
// one deque cell: holds a word and an occupied flag, shifts with its neighbors
module dqe_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dqe_pkg::cell_ctrl_t   ctrl,
    input  logic [DATA_WIDTH-1:0] push_word,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic                  left_occ,
    input  logic [DATA_WIDTH-1:0] right_data,
    input  logic                  right_occ,
    output logic [DATA_WIDTH-1:0] data,
    output logic                  occ
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  occ_reg;
    logic                  occ_next;

    // next value from the broadcast control and the neighbors
    always_comb
    begin
        data_next = data_reg;
        occ_next  = occ_reg;
        priority if (ctrl.push_front)
        begin
            // everything moves one cell toward the rear
            data_next = left_data;
            occ_next  = left_occ;
        end
        else if (ctrl.push_rear)
        begin
            // first free cell behind the last occupied one takes the word
            if (!occ_reg && left_occ)
            begin
                data_next = push_word;
                occ_next  = 1'b1;
            end
        end
        else if (ctrl.pop_front)
        begin
            // everything moves one cell toward the front
            data_next = right_data;
            occ_next  = right_occ;
        end
        else if (ctrl.pop_rear)
        begin
            // the rear cell lets go of its word
            if (occ_reg && !right_occ)
            begin
                occ_next = 1'b0;
            end
        end
        else
        begin
            // no applied operation: hold
        end
    end

    // occupied flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // stored word, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign occ  = occ_reg;

endmodule

// ----- rtl/double_ended_queue_top.sv -----
// top level of the bounded double-ended queue built from a chain of cells
//
// Bounded deque of DEPTH words held in a row of cells; the front sits in
// cell 0 and all cells shift together on a push or pop at the front. busy
// is always low: a transaction is taken in every cycle that start is high.
// Each transaction gives exactly one result: strobe goes high for one cycle
// after pend_reg and then strobe_reg have registered the accept, and the
// result is held in result_reg while strobe is high; results come in order
// at up to one per cycle, and the receiver cannot hold them off. The rear
// word is picked by an OR across the cells that flag the last occupied
// place, which sets the depth of the result path. A pop on an empty deque
// is ignored with status 1, a push on a full deque is dropped with
// status 2, and an empty deque reports zero front and rear words.
module double_ended_queue_top #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  dqe_pkg::in_item_t   item,
    output logic                strobe,
    output dqe_pkg::out_item_t  result
);

    localparam int CW = $clog2(DEPTH + 1);

    logic                  accept;
    logic [DATA_WIDTH-1:0] push_word;
    dqe_pkg::cell_ctrl_t   ctrl;
    dqe_pkg::status_t      status_now;
    logic                  is_push;
    logic                  is_pop;

    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    dqe_pkg::status_t      status_reg;
    logic                  pend_reg;
    logic                  strobe_reg;
    dqe_pkg::out_item_t    result_reg;
    dqe_pkg::out_item_t    result_next;

    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic                  cell_occ  [DEPTH];
    logic [DATA_WIDTH-1:0] rear_gated [DEPTH];
    logic [DATA_WIDTH-1:0] rear_word;
    logic [DATA_WIDTH-1:0] front_word;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // input word kept in its low DATA_WIDTH bits
    assign push_word = DATA_WIDTH'(64'($unsigned(item.push_value)));

    // decode opcode against the current fill level
    always_comb
    begin
        is_push    = (item.opcode == dqe_pkg::OP_PUSH_FRONT) ||
                     (item.opcode == dqe_pkg::OP_PUSH_REAR);
        is_pop     = (item.opcode == dqe_pkg::OP_POP_FRONT) ||
                     (item.opcode == dqe_pkg::OP_POP_REAR);
        status_now = dqe_pkg::ST_DONE;
        if (is_push && (count_reg == CW'(DEPTH)))
        begin
            status_now = dqe_pkg::ST_PUSH_FULL;
        end
        else if (is_pop && (count_reg == '0))
        begin
            status_now = dqe_pkg::ST_POP_EMPTY;
        end
        ctrl.push_front = accept && (status_now == dqe_pkg::ST_DONE) &&
                          (item.opcode == dqe_pkg::OP_PUSH_FRONT);
        ctrl.push_rear  = accept && (status_now == dqe_pkg::ST_DONE) &&
                          (item.opcode == dqe_pkg::OP_PUSH_REAR);
        ctrl.pop_front  = accept && (status_now == dqe_pkg::ST_DONE) &&
                          (item.opcode == dqe_pkg::OP_POP_FRONT);
        ctrl.pop_rear   = accept && (status_now == dqe_pkg::ST_DONE) &&
                          (item.opcode == dqe_pkg::OP_POP_REAR);
    end

    // occupancy follows the applied operation
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.push_front || ctrl.push_rear)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctrl.pop_front || ctrl.pop_rear)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // row of cells, front at cell 0, push input enters at the left end
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_data;
        logic                  left_occ;
        logic [DATA_WIDTH-1:0] right_data;
        logic                  right_occ;

        if (i == 0)
        begin : g_left_end
            assign left_data = push_word;
            assign left_occ  = 1'b1;
        end
        else
        begin : g_left_link
            assign left_data = cell_data[i-1];
            assign left_occ  = cell_occ[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_right_end
            assign right_data = '0;
            assign right_occ  = 1'b0;
        end
        else
        begin : g_right_link
            assign right_data = cell_data[i+1];
            assign right_occ  = cell_occ[i+1];
        end

        dqe_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .push_word  (push_word),
            .left_data  (left_data),
            .left_occ   (left_occ),
            .right_data (right_data),
            .right_occ  (right_occ),
            .data       (cell_data[i]),
            .occ        (cell_occ[i])
        );

        // the last occupied cell offers its word as the rear
        assign rear_gated[i] = (cell_occ[i] && !right_occ) ? cell_data[i] : '0;
    end

    // rear word: OR across the flagged cells, at most one is set
    always_comb
    begin
        rear_word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rear_word = rear_word | rear_gated[i];
        end
    end

    assign front_word = cell_occ[0] ? cell_data[0] : '0;

    // result from the updated cell row
    always_comb
    begin
        result_next.front_value = 32'(64'(front_word));
        result_next.rear_value  = 32'(64'(rear_word));
        result_next.is_empty    = (count_reg == '0);
        result_next.is_full     = (count_reg == CW'(DEPTH));
        result_next.occupancy   = 5'(64'(count_reg));
        result_next.status      = status_reg;
    end

    // control state: fill level and the two result stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            pend_reg   <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            pend_reg   <= accept;
            strobe_reg <= pend_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_now;
        end
        if (pend_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule
